/* rtl/core/fir_pkg.sv */
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, input codes and control types of the gain-scaled FIR
// filter.
// ----------------------------------------------------------------------------
package fir_pkg;

	// default configuration
	localparam int TAPS_DEF       = 16;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 15;

	// accumulator width plus data width
	localparam int ACC_SPAN = 63;

	// width of the coefficient index field
	localparam int TAP_INDEX_W = 4;

	// input word kinds
	localparam logic KIND_COEF   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// control from the top level to the tap engine
	typedef struct packed {
		logic coef_we;
		logic samp_we;
	} taps_ctrl_t;

	// status from the tap engine
	typedef struct packed {
		logic busy;
		logic sat;
	} taps_stat_t;

endpackage

/* rtl/core/fir_if.sv */
// ----------------------------------------------------------------------------
// fir_if
// Valid/ready channels of the FIR filter: input words, gain writes and
// filter results.
// ----------------------------------------------------------------------------

// input word: coefficient write or new sample
interface fir_in_if #(
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF
);
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [fir_pkg::TAP_INDEX_W-1:0]     tap_index;
	logic signed [DATA_WIDTH-1:0]        value;

	modport source (output valid, kind, tap_index, value, input ready);
	modport sink (input valid, kind, tap_index, value, output ready);
endinterface

// gain register write
interface fir_cfg_if #(
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// filter result
interface fir_out_if #(
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] filtered;
	logic                         saturated;

	modport source (output valid, filtered, saturated, input ready);
	modport sink (input valid, filtered, saturated, output ready);
endinterface

/* rtl/core/fir_filter_with_gain.sv */
// ----------------------------------------------------------------------------
// fir_filter_with_gain
// Direct-form FIR filter with a programmable output gain and saturation.
//
//   channel  dir  word                               handshake
//   item     in   kind, tap_index, value             valid/ready
//   cfg      in   data (gain register)               valid/ready
//   result   out  filtered, saturated                valid/ready
//
// A coefficient word is taken without leaving the idle state. A sample
// word holds off the input while the taps pass one at a time through the
// single tap multiplier, the multiply/accumulate pipeline drains, the gain
// engine starts, the bit-serial gain multiply runs over every gain bit and
// the output register is loaded; the next word is taken only after the
// return to idle. Reset empties the coefficient table and sample history,
// which then read as zero, and sets gain to just below one. A new word is
// taken while a result still waits on the output register; the next result
// waits in the gain step until that register is free.
// ----------------------------------------------------------------------------
module fir_filter_with_gain #(
	parameter int TAPS       = fir_pkg::TAPS_DEF,
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = fir_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fir_in_if.sink     item,
	fir_cfg_if.sink    cfg,
	fir_out_if.source  result
);
	import fir_pkg::*;

	localparam int ACC_WIDTH = ACC_SPAN - DATA_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MAC  = 3'b010,
		ST_GAIN = 3'b100
	} state_t;

	state_t                       state_q;
	logic signed [DATA_WIDTH-1:0] gain_q;
	taps_ctrl_t                   taps_ctrl;
	taps_stat_t                   taps_stat;
	logic signed [ACC_WIDTH-1:0]  acc;
	logic                         accept;
	logic                         gain_start;
	logic                         gain_busy;
	logic signed [DATA_WIDTH-1:0] gain_y;
	logic                         gain_sat;
	logic                         out_free;
	logic                         out_load;
	logic                         res_valid_q;
	logic signed [DATA_WIDTH-1:0] filtered_q;
	logic                         saturated_q;

	// gain register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= {1'b0, {(DATA_WIDTH - 1){1'b1}}};
		end else if (cfg.valid) begin
			gain_q <= cfg.data;
		end
	end

	// input word decode
	assign item.ready        = (state_q == ST_IDLE);
	assign accept            = item.valid && item.ready;
	assign taps_ctrl.coef_we = accept && (item.kind == KIND_COEF);
	assign taps_ctrl.samp_we = accept && (item.kind == KIND_SAMPLE);

	// handoffs between engines and to the output register
	assign gain_start = (state_q == ST_MAC) && !taps_stat.busy;
	assign out_free   = !res_valid_q || result.ready;
	assign out_load   = (state_q == ST_GAIN) && !gain_busy && out_free;

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (taps_ctrl.samp_we) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (gain_start) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q  <= gain_y;
			saturated_q <= gain_sat;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.filtered  = filtered_q;
	assign result.saturated = saturated_q;

	// tap multiply-accumulate
	fir_taps #(
		.TAPS       (TAPS),
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_taps (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (taps_ctrl),
		.tap_index (item.tap_index),
		.value     (item.value),
		.acc       (acc),
		.stat      (taps_stat)
	);

	// gain scaling and output clamp
	fir_gain #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (gain_start),
		.gain      (gain_q),
		.acc       (acc),
		.acc_sat   (taps_stat.sat),
		.filtered  (gain_y),
		.saturated (gain_sat),
		.busy      (gain_busy)
	);

	// the two engines never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(taps_stat.busy && gain_busy))
		else $error("tap engine and gain engine busy together");

	// gain engine starts right after the accumulator settles
	a_gain_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) && !taps_stat.busy |=> gain_busy)
		else $error("gain engine did not start");

	// a result only appears out of the gain step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_GAIN))
		else $error("result word loaded outside the gain step");

endmodule

/* rtl/core/fir_taps.sv */
// ----------------------------------------------------------------------------
// fir_taps
// Coefficient and sample memories with a one-tap-per-cycle multiply and
// saturating accumulate pipeline.
// ----------------------------------------------------------------------------
module fir_taps #(
	parameter int TAPS       = fir_pkg::TAPS_DEF,
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = fir_pkg::FRAC_BITS_DEF,
	parameter int ACC_WIDTH  = fir_pkg::ACC_SPAN - DATA_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fir_pkg::taps_ctrl_t              ctrl,
	input  logic [fir_pkg::TAP_INDEX_W-1:0]  tap_index,
	input  logic signed [DATA_WIDTH-1:0]     value,
	output logic signed [ACC_WIDTH-1:0]      acc,
	output fir_pkg::taps_stat_t              stat
);
	import fir_pkg::*;

	localparam int AW = $clog2(TAPS);
	localparam int FW = $clog2(TAPS + 1);
	localparam int IW = ((AW > TAP_INDEX_W) ? AW : TAP_INDEX_W) + 1;
	localparam int PW = 2 * DATA_WIDTH;
	localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;

	logic signed [DATA_WIDTH-1:0] cmem [TAPS];
	logic signed [DATA_WIDTH-1:0] smem [TAPS];
	logic [TAPS-1:0]              cvalid_q;
	logic [AW-1:0]                wptr_q;
	logic [AW-1:0]                rptr_q;
	logic [AW-1:0]                k_q;
	logic [AW-1:0]                wptr_nxt;
	logic [AW-1:0]                rptr_dec;
	logic [FW-1:0]                fill_q;
	logic                         issue_q;
	logic [IW-1:0]                cidx;
	logic                         cwr_ok;

	logic signed [DATA_WIDTH-1:0] coef_s1;
	logic signed [DATA_WIDTH-1:0] samp_s1;
	logic                         cval_s1;
	logic                         sval_s1;
	logic                         go_s1;
	logic signed [PW-1:0]         prod_s2;
	logic                         go_s2;

	logic signed [DATA_WIDTH-1:0] op_c;
	logic signed [DATA_WIDTH-1:0] op_s;
	logic signed [PW-1:0]         prod_sh;
	logic signed [SW-1:0]         sum;
	logic signed [SW-1:0]         acc_hi;
	logic signed [SW-1:0]         acc_lo;
	logic signed [ACC_WIDTH-1:0]  acc_nxt;
	logic                         acc_ovf;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic                         sat_q;

	// coefficient index range check
	assign cidx   = IW'(tap_index);
	assign cwr_ok = ctrl.coef_we && (cidx < IW'(TAPS));

	// circular pointer steps
	assign wptr_nxt = (wptr_q == AW'(TAPS - 1)) ? '0 : wptr_q + 1'b1;
	assign rptr_dec = (rptr_q == '0) ? AW'(TAPS - 1) : rptr_q - 1'b1;

	// memory writes
	always_ff @(posedge clk) begin
		if (cwr_ok) begin
			cmem[cidx[AW-1:0]] <= value;
		end
		if (ctrl.samp_we) begin
			smem[wptr_nxt] <= value;
		end
	end

	// sequencing: pointers, fill count, tap counter, stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= '0;
			wptr_q   <= '0;
			rptr_q   <= '0;
			k_q      <= '0;
			fill_q   <= '0;
			issue_q  <= 1'b0;
			go_s1    <= 1'b0;
			go_s2    <= 1'b0;
		end else begin
			if (cwr_ok) begin
				cvalid_q[cidx[AW-1:0]] <= 1'b1;
			end
			if (ctrl.samp_we) begin
				wptr_q  <= wptr_nxt;
				rptr_q  <= wptr_nxt;
				k_q     <= '0;
				issue_q <= 1'b1;
				if (fill_q != FW'(TAPS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (issue_q) begin
				k_q    <= k_q + 1'b1;
				rptr_q <= rptr_dec;
				if (k_q == AW'(TAPS - 1)) begin
					issue_q <= 1'b0;
				end
			end
			go_s1 <= issue_q;
			go_s2 <= go_s1;
		end
	end

	// unwritten coefficients and samples from before start-up read as zero
	assign op_c = cval_s1 ? coef_s1 : '0;
	assign op_s = sval_s1 ? samp_s1 : '0;

	// floor shift of the product and saturating add
	assign prod_sh = prod_s2 >>> FRAC_BITS;
	assign sum     = SW'(acc_q) + SW'(prod_sh);
	assign acc_hi  = SW'({1'b0, {(ACC_WIDTH - 1){1'b1}}});
	assign acc_lo  = ~acc_hi;

	always_comb begin
		acc_ovf = 1'b0;
		acc_nxt = ACC_WIDTH'(sum);
		if (sum > acc_hi) begin
			acc_ovf = 1'b1;
			acc_nxt = ACC_WIDTH'(acc_hi);
		end else if (sum < acc_lo) begin
			acc_ovf = 1'b1;
			acc_nxt = ACC_WIDTH'(acc_lo);
		end
	end

	// read, multiply and accumulate stages
	always_ff @(posedge clk) begin
		coef_s1 <= cmem[k_q];
		samp_s1 <= smem[rptr_q];
		cval_s1 <= cvalid_q[k_q];
		sval_s1 <= FW'(k_q) < fill_q;
		prod_s2 <= op_c * op_s;
		if (ctrl.samp_we) begin
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (go_s2) begin
			acc_q <= acc_nxt;
			sat_q <= sat_q | acc_ovf;
		end
	end

	assign acc       = acc_q;
	assign stat.busy = issue_q | go_s1 | go_s2;
	assign stat.sat  = sat_q;

endmodule

/* rtl/core/fir_gain.sv */
// ----------------------------------------------------------------------------
// fir_gain
// Bit-serial gain multiply of the accumulator, most significant gain bit
// first, then floor shift and output saturation.
// ----------------------------------------------------------------------------
module fir_gain #(
	parameter int DATA_WIDTH = fir_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = fir_pkg::FRAC_BITS_DEF,
	parameter int ACC_WIDTH  = fir_pkg::ACC_SPAN - DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DATA_WIDTH-1:0] gain,
	input  logic signed [ACC_WIDTH-1:0]  acc,
	input  logic                         acc_sat,
	output logic signed [DATA_WIDTH-1:0] filtered,
	output logic                         saturated,
	output logic                         busy
);
	import fir_pkg::*;

	localparam int PW = ACC_WIDTH + DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH);

	logic signed [PW-1:0]   prod_q;
	logic [DATA_WIDTH-1:0]  gsh_q;
	logic [CW-1:0]          cnt_q;
	logic                   run_q;
	logic signed [PW-1:0]   addend;
	logic signed [PW-1:0]   shifted;
	logic signed [PW-1:0]   lim_hi;
	logic signed [PW-1:0]   lim_lo;

	// partial product for the current gain bit
	assign addend = gsh_q[DATA_WIDTH-1] ? PW'(acc) : '0;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DATA_WIDTH - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// shift-add: sign bit weighs negative, the rest double and add
	always_ff @(posedge clk) begin
		if (start) begin
			gsh_q <= gain;
		end else if (run_q) begin
			gsh_q <= gsh_q << 1;
			if (cnt_q == '0) begin
				prod_q <= -addend;
			end else begin
				prod_q <= (prod_q <<< 1) + addend;
			end
		end
	end

	// floor shift and clamp to the data range
	assign shifted = prod_q >>> FRAC_BITS;
	assign lim_hi  = {{(ACC_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	assign lim_lo  = ~lim_hi;

	always_comb begin
		saturated = acc_sat;
		filtered  = DATA_WIDTH'(shifted);
		if (shifted > lim_hi) begin
			saturated = 1'b1;
			filtered  = DATA_WIDTH'(lim_hi);
		end else if (shifted < lim_lo) begin
			saturated = 1'b1;
			filtered  = DATA_WIDTH'(lim_lo);
		end
	end

	assign busy = run_q;

endmodule
